// ===== rtl/core/scl_pkg.sv =====
// ----------------------------------------------------------------------------
// scl_pkg
// Shared types and constants of the serial command line classifier: command
// codes, LOG port parser phases, command prefix table and control structs.
// ----------------------------------------------------------------------------
package scl_pkg;

  // Result command codes
  typedef enum logic [3:0] {
    CMD_HEADER      = 4'd0,
    CMD_STATUSDEF   = 4'd1,
    CMD_STATUS      = 4'd2,
    CMD_DFU         = 4'd3,
    CMD_CAL_W       = 4'd4,
    CMD_CAL_R       = 4'd5,
    CMD_CAL_ENTRIES = 4'd6,
    CMD_LOG         = 4'd7,
    CMD_OTP_R       = 4'd8,
    CMD_OTP_W       = 4'd9,
    CMD_BOARD_UNDEF = 4'd10,
    CMD_FALLBACK    = 4'd11
  } cmd_t;

  // Phases of the LOG port parser
  typedef enum logic [2:0] {
    PH_IDLE     = 3'd0,
    PH_EXPECT_P = 3'd1,
    PH_BLANK    = 3'd2,
    PH_PLUS     = 3'd3,
    PH_MINUS    = 3'd4,
    PH_POS      = 3'd5,
    PH_NEG      = 3'd6,
    PH_STOP     = 3'd7
  } port_phase_t;

  // Handler enable bit positions
  localparam int unsigned H_HEADER     = 0;
  localparam int unsigned H_BOOTLOADER = 1;
  localparam int unsigned H_CAL        = 2;
  localparam int unsigned H_CAL_RW     = 3;
  localparam int unsigned H_LOG        = 4;
  localparam int unsigned H_OTP_R      = 5;
  localparam int unsigned H_OTP_W      = 6;
  localparam int unsigned H_BOARD_UNDEF = 7;

  // Prefix table, in match priority order
  localparam int unsigned NUM_PREFIX = 7;
  localparam int unsigned PREFIX_MAX = 9;

  localparam int unsigned P_SERIAL    = 0;
  localparam int unsigned P_STATUSDEF = 1;
  localparam int unsigned P_STATUS    = 2;
  localparam int unsigned P_DFU       = 3;
  localparam int unsigned P_CAL       = 4;
  localparam int unsigned P_LOG       = 5;
  localparam int unsigned P_OTP       = 6;

  typedef logic [7:0] char_t;

  localparam char_t PREFIX_TEXT [NUM_PREFIX][PREFIX_MAX] = '{
    '{"S", "e", "r", "i", "a", "l", 8'h00, 8'h00, 8'h00},
    '{"S", "t", "a", "t", "u", "s", "D", "e", "f"},
    '{"S", "t", "a", "t", "u", "s", 8'h00, 8'h00, 8'h00},
    '{"D", "F", "U", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{"C", "A", "L", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{"L", "O", "G", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{"O", "T", "P", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00}
  };

  localparam logic [3:0] PREFIX_LEN [NUM_PREFIX] = '{
    4'd6, 4'd9, 4'd6, 4'd3, 4'd3, 4'd3, 4'd3
  };

  // Characters of interest
  localparam char_t CH_CR    = 8'd13;
  localparam char_t CH_LF    = 8'd10;
  localparam char_t CH_SPACE = 8'd32;
  localparam char_t CH_NUL   = 8'd0;
  localparam char_t CH_R     = 8'd114;
  localparam char_t CH_W     = 8'd119;
  localparam char_t CH_P     = 8'd112;
  localparam char_t CH_PLUS  = 8'd43;
  localparam char_t CH_MINUS = 8'd45;
  localparam char_t CH_ZERO  = 8'd48;
  localparam char_t CH_NINE  = 8'd57;
  localparam char_t CH_TAB   = 8'd9;

  // Input kinds
  localparam logic KIND_BYTE  = 1'b0;
  localparam logic KIND_FLUSH = 1'b1;

  // Control from the line tracker to the port parser
  typedef struct packed {
    logic step;   // advance on the current byte
    logic start;  // first space seen: expect 'p' next
    logic clear;  // end of line or flush
  } port_ctrl_t;

  // Port parser state after the current byte
  typedef struct packed {
    logic               ok;
    logic signed [31:0] value;
  } port_stat_t;

endpackage

// ===== rtl/core/scl_port_parser.sv =====
// ----------------------------------------------------------------------------
// scl_port_parser
// Decimal parser for the argument of a LOG line: 'p', optional blanks, an
// optional sign and digits, saturating to the signed 32-bit range.
// ----------------------------------------------------------------------------
module scl_port_parser (
  input  logic               clk,
  input  logic               rst,
  input  scl_pkg::port_ctrl_t ctrl,
  input  logic [7:0]         rx_byte,
  output scl_pkg::port_stat_t stat
);
  import scl_pkg::*;

  localparam logic signed [35:0] SAT_MAX = 36'sd2147483647;
  localparam logic signed [35:0] SAT_MIN = -36'sd2147483648;

  port_phase_t        phase;
  port_phase_t        phase_next;
  logic signed [31:0] acc;
  logic signed [31:0] acc_next;
  logic               ok;
  logic               ok_next;

  logic               is_digit;
  logic               is_blank;
  logic signed [35:0] acc_ext;
  logic signed [35:0] times10;
  logic signed [35:0] digit_ext;
  logic signed [35:0] pos_sum;
  logic signed [35:0] neg_sum;

  // Classify the byte and form the shift-add products
  assign is_digit  = (rx_byte >= CH_ZERO) && (rx_byte <= CH_NINE);
  assign is_blank  = (rx_byte == CH_SPACE) || ((rx_byte >= CH_TAB) && (rx_byte <= CH_CR));
  assign acc_ext   = {{4{acc[31]}}, acc};
  assign times10   = (acc_ext <<< 3) + (acc_ext <<< 1);
  assign digit_ext = {32'd0, rx_byte[3:0]};
  assign pos_sum   = times10 + digit_ext;
  assign neg_sum   = times10 - digit_ext;

  // Next phase, value and valid flag after this byte
  always_comb begin
    phase_next = phase;
    acc_next   = acc;
    ok_next    = ok;
    if (ctrl.step) begin
      unique case (phase)
        PH_EXPECT_P: begin
          phase_next = (rx_byte == CH_P) ? PH_BLANK : PH_STOP;
        end
        PH_BLANK: begin
          if (is_blank) begin
            phase_next = PH_BLANK;
          end else if (rx_byte == CH_PLUS) begin
            phase_next = PH_PLUS;
          end else if (rx_byte == CH_MINUS) begin
            phase_next = PH_MINUS;
          end else if (is_digit) begin
            acc_next   = digit_ext[31:0];
            ok_next    = 1'b1;
            phase_next = PH_POS;
          end else begin
            phase_next = PH_STOP;
          end
        end
        PH_PLUS, PH_MINUS: begin
          if (is_digit) begin
            acc_next   = (phase == PH_PLUS) ? digit_ext[31:0] : 32'(-digit_ext);
            ok_next    = 1'b1;
            phase_next = (phase == PH_PLUS) ? PH_POS : PH_NEG;
          end else begin
            phase_next = PH_STOP;
          end
        end
        PH_POS: begin
          if (is_digit) begin
            acc_next = (pos_sum > SAT_MAX) ? SAT_MAX[31:0] : pos_sum[31:0];
          end else begin
            phase_next = PH_STOP;
          end
        end
        PH_NEG: begin
          if (is_digit) begin
            acc_next = (neg_sum < SAT_MIN) ? SAT_MIN[31:0] : neg_sum[31:0];
          end else begin
            phase_next = PH_STOP;
          end
        end
        default: begin
          phase_next = phase;
        end
      endcase
      // The first space of the line arms the parser
      if (ctrl.start) begin
        phase_next = PH_EXPECT_P;
      end
    end
  end

  assign stat.ok    = ok_next;
  assign stat.value = acc_next;

  // Hold parser state; drop it at line end or flush
  always_ff @(posedge clk) begin
    if (rst || ctrl.clear) begin
      phase <= PH_IDLE;
      acc   <= '0;
      ok    <= 1'b0;
    end else begin
      phase <= phase_next;
      acc   <= acc_next;
      ok    <= ok_next;
    end
  end

endmodule

// ===== rtl/core/serial_command_line_classifier_top.sv =====
// ----------------------------------------------------------------------------
// serial_command_line_classifier_top
// Assembles received bytes into lines and classifies each completed line
// into a command code, with the decimal port of a LOG line.
// ----------------------------------------------------------------------------
//  channel   dir  handshake          payload
//  s_*       in   s_tvalid/s_tready  s_tdata: rx_byte; s_tuser: kind
//  m_*       out  m_tvalid/m_tready  m_tdata: command, log_port, line_length,
//                                    truncated
//  handlers  in   handlers_we        handlers_wdata: handler enable mask
//
//  One byte per cycle while the output register is not stalled: a transfer
//  lands in the input register, and when it is processed the line state
//  advances and the result of a completed line loads the output register.
//  The cycle is bounded by the LOG port multiply-by-ten and saturate.
//  Reset is synchronous and clears all line state; the mask resets to all
//  ones. A stalled output register holds both stages.
// ----------------------------------------------------------------------------
module serial_command_line_classifier_top #(
  parameter int unsigned LINE_LIMIT = 512
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,          // [7:0] rx_byte
  input  logic [0:0]  s_tuser,          // [0] kind
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [47:0] m_tdata,          // [3:0] command, [35:4] log_port,
                                        // [44:36] line_length, [45] truncated
  input  logic        handlers_we,
  input  logic [7:0]  handlers_wdata
);
  import scl_pkg::*;

  localparam int unsigned CW = $clog2(LINE_LIMIT);
  localparam logic [CW-1:0] LAST_COUNT = CW'(LINE_LIMIT - 1);

  // Configuration
  logic [7:0] handlers;

  // Input register
  logic       in_valid;
  logic       in_kind;
  logic [7:0] in_byte;

  // Line state
  logic [CW-1:0]         line_count;
  logic [NUM_PREFIX-1:0] prefix_flags;
  logic                  space_seen;
  logic [7:0]            char_after_space;
  logic [7:0]            char_at_four;
  logic                  nul_seen;
  logic                  want_next;

  logic [CW-1:0]         line_count_next;
  logic [NUM_PREFIX-1:0] prefix_flags_next;
  logic                  space_seen_next;
  logic [7:0]            char_after_space_next;
  logic [7:0]            char_at_four_next;
  logic                  nul_seen_next;
  logic                  want_next_next;

  // Output register
  logic        out_valid;
  cmd_t        out_command;
  logic [31:0] out_log_port;
  logic [8:0]  out_line_length;
  logic        out_truncated;

  // Step control
  logic       advance;
  logic       proc;
  logic       is_term;
  logic       take;
  logic       finish;
  logic       trunc;
  logic       clear_line;
  logic [3:0] pos_idx;

  // Classification
  logic [NUM_PREFIX-1:0] has_prefix;
  cmd_t                  cmd;
  cmd_t                  undef_cmd;
  logic [31:0]           port_val;
  logic                  emit;
  logic [CW+8:0]         len_wide;

  port_ctrl_t pctrl;
  port_stat_t pstat;

  // Stall both stages while a result waits
  assign advance  = !out_valid || m_tready;
  assign s_tready = !in_valid || advance;
  assign proc     = in_valid && advance;

  assign is_term = (in_byte == CH_CR) || (in_byte == CH_LF);
  assign take    = (in_kind == KIND_BYTE) && !is_term;
  assign pos_idx = (line_count < CW'(PREFIX_MAX)) ? line_count[3:0] : 4'd0;

  // Line state after the byte in the input register
  always_comb begin
    line_count_next       = line_count;
    prefix_flags_next     = prefix_flags;
    space_seen_next       = space_seen;
    char_after_space_next = char_after_space;
    char_at_four_next     = char_at_four;
    nul_seen_next         = nul_seen;
    want_next_next        = want_next;
    if (take) begin
      for (int k = 0; k < NUM_PREFIX; k++) begin
        if ((line_count < CW'(PREFIX_LEN[k])) && (in_byte != PREFIX_TEXT[k][pos_idx])) begin
          prefix_flags_next[k] = 1'b0;
        end
      end
      if (line_count == CW'(4)) begin
        char_at_four_next = in_byte;
      end
      if (!nul_seen) begin
        if (want_next) begin
          char_after_space_next = in_byte;
          want_next_next        = 1'b0;
        end
        if ((in_byte == CH_SPACE) && !space_seen) begin
          space_seen_next       = 1'b1;
          want_next_next        = 1'b1;
          char_after_space_next = 8'd0;
        end
        if (in_byte == CH_NUL) begin
          nul_seen_next = 1'b1;
        end
      end
      line_count_next = line_count + CW'(1);
    end
  end

  // End of line: terminator on a non-empty line, or length limit
  assign trunc      = take && (line_count_next >= LAST_COUNT);
  assign finish     = (in_kind == KIND_BYTE) &&
                      ((is_term && (line_count != '0)) || trunc);
  assign clear_line = (in_kind == KIND_FLUSH) || finish;

  assign pctrl.step  = proc && take && !nul_seen;
  assign pctrl.start = pctrl.step && (in_byte == CH_SPACE) && !space_seen;
  assign pctrl.clear = proc && clear_line;

  scl_port_parser u_port (
    .clk     (clk),
    .rst     (rst),
    .ctrl    (pctrl),
    .rx_byte (in_byte),
    .stat    (pstat)
  );

  // Prefix hits need the full prefix length
  always_comb begin
    for (int k = 0; k < NUM_PREFIX; k++) begin
      has_prefix[k] = prefix_flags_next[k] && (line_count_next >= CW'(PREFIX_LEN[k]));
    end
  end

  assign undef_cmd = handlers[H_BOARD_UNDEF] ? CMD_BOARD_UNDEF : CMD_FALLBACK;

  // Resolve the command in prefix priority order
  always_comb begin
    cmd      = undef_cmd;
    port_val = 32'd0;
    emit     = 1'b1;
    if (has_prefix[P_SERIAL]) begin
      cmd = handlers[H_HEADER] ? CMD_HEADER : CMD_FALLBACK;
    end else if (has_prefix[P_STATUSDEF]) begin
      cmd = CMD_STATUSDEF;
    end else if (has_prefix[P_STATUS]) begin
      cmd = CMD_STATUS;
    end else if (has_prefix[P_DFU]) begin
      cmd = handlers[H_BOOTLOADER] ? CMD_DFU : CMD_FALLBACK;
    end else if (has_prefix[P_CAL]) begin
      if (!handlers[H_CAL]) begin
        cmd = CMD_FALLBACK;
      end else if (!space_seen_next) begin
        cmd = undef_cmd;
      end else if ((char_after_space_next == CH_W) || (char_after_space_next == CH_R)) begin
        cmd  = (char_after_space_next == CH_W) ? CMD_CAL_W : CMD_CAL_R;
        emit = handlers[H_CAL_RW];
      end else begin
        cmd = CMD_CAL_ENTRIES;
      end
    end else if (has_prefix[P_LOG]) begin
      if (!handlers[H_LOG]) begin
        cmd = CMD_FALLBACK;
      end else if (space_seen_next && pstat.ok) begin
        cmd      = CMD_LOG;
        port_val = pstat.value;
      end else begin
        cmd = undef_cmd;
      end
    end else if (has_prefix[P_OTP]) begin
      cmd = CMD_FALLBACK;
      if (line_count_next >= CW'(5)) begin
        if ((char_at_four_next == CH_R) && handlers[H_OTP_R]) begin
          cmd = CMD_OTP_R;
        end else if ((char_at_four_next == CH_W) && handlers[H_OTP_W]) begin
          cmd = CMD_OTP_W;
        end
      end
    end
  end

  assign len_wide = {9'd0, line_count_next};

  // Configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      handlers <= 8'hFF;
    end else if (handlers_we) begin
      handlers <= handlers_wdata;
    end
  end

  // Input register: load on transfer, empty when processed
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tvalid && s_tready) begin
      in_valid <= 1'b1;
    end else if (proc) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_kind <= s_tuser[0];
      in_byte <= s_tdata;
    end
  end

  // Line state: advance on each processed item, drop at line end or flush
  always_ff @(posedge clk) begin
    if (rst || (proc && clear_line)) begin
      line_count       <= '0;
      prefix_flags     <= '1;
      space_seen       <= 1'b0;
      char_after_space <= 8'd0;
      char_at_four     <= 8'd0;
      nul_seen         <= 1'b0;
      want_next        <= 1'b0;
    end else if (proc) begin
      line_count       <= line_count_next;
      prefix_flags     <= prefix_flags_next;
      space_seen       <= space_seen_next;
      char_after_space <= char_after_space_next;
      char_at_four     <= char_at_four_next;
      nul_seen         <= nul_seen_next;
      want_next        <= want_next_next;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= proc && finish && emit;
    end
  end

  always_ff @(posedge clk) begin
    if (proc && finish) begin
      out_command     <= cmd;
      out_log_port    <= port_val;
      out_line_length <= len_wide[8:0];
      out_truncated   <= trunc;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {2'b00, out_truncated, out_line_length, out_log_port, out_command};

  // Checks
  a_len_nonzero: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_line_length != 9'd0 || LINE_LIMIT > 512))
    else $error("result with empty line");

  a_port_only_log: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_log_port != 32'd0) |-> (out_command == CMD_LOG))
    else $error("nonzero port on a non-LOG command");

  a_flush_clears: assert property (@(posedge clk) disable iff (rst)
    (proc && in_kind == KIND_FLUSH) |=> (line_count == '0 && prefix_flags == '1))
    else $error("flush left line state");

  a_result_after_item: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(proc && finish))
    else $error("result without a line end");

endmodule
